// File: rtl/core/sirf_pkg.sv
// Package for the square image rotate/flip block: sizes, beat structs,
// mode codes and the raster/mapping address functions.
// No dependencies.
package sirf_pkg;

  localparam int unsigned SIDE         = 8;
  localparam int unsigned SIDE_W       = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int unsigned FRAME_PIXELS = SIDE * SIDE;
  localparam int unsigned STORE_DEPTH  = 2 * FRAME_PIXELS;
  localparam int unsigned ADDR_W       = $clog2(STORE_DEPTH);
  localparam int unsigned PIX_W        = 8;

  localparam logic [SIDE_W-1:0] SIDE_LAST = SIDE_W'(SIDE - 1);

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    MODE_CW   = 2'd0,
    MODE_CCW  = 2'd1,
    MODE_ROWS = 2'd2,
    MODE_COLS = 2'd3
  } mode_e;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             frame_last;
  } out_beat_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic head_valid;
    logic skid_valid;
  } ob_status_t;

  // bank * N*N + row * N + col
  function automatic logic [ADDR_W-1:0] raster_addr(logic bank, logic [SIDE_W-1:0] row,
                                                    logic [SIDE_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = bank ? ADDR_W'(FRAME_PIXELS) : '0;
    return base + ADDR_W'(row) * ADDR_W'(SIDE) + ADDR_W'(col);
  endfunction

  // Source address in the held bank for output position (row, col).
  function automatic logic [ADDR_W-1:0] map_addr(logic bank, logic [SIDE_W-1:0] row,
                                                 logic [SIDE_W-1:0] col, mode_e mode);
    logic [SIDE_W-1:0] sr;
    logic [SIDE_W-1:0] sc;
    case (mode)
      MODE_CW: begin
        sr = SIDE_LAST - col;
        sc = row;
      end
      MODE_CCW: begin
        sr = col;
        sc = SIDE_LAST - row;
      end
      MODE_ROWS: begin
        sr = SIDE_LAST - row;
        sc = col;
      end
      default: begin
        sr = row;
        sc = SIDE_LAST - col;
      end
    endcase
    return raster_addr(bank, sr, sc);
  endfunction

endpackage

// File: rtl/core/square_image_rotate_flip.sv
// Top level of the square image rotate/flip block: fill/emit counters,
// bank control and the mode register. Depends on sirf_pkg, sirf_frame_mem
// and sirf_out_buf.
//
// Usage: input beats carry {kind, pixel}. A pixel beat writes the next raster
// position of the filling bank; a drain beat writes nothing. While a completed
// frame is held, every accepted input beat emits one pixel of it, in output
// raster order, read through the mapping selected by the mode register
// (cw, ccw, row swap, column swap). Completing a frame swaps banks and restarts
// emission at the new frame, dropping what was left of the old one.
// Throughput: one input beat per clock while in_ready_o is high. A result is
// registered by the synchronous memory read and then by the output buffer
// before it appears on the output channel.
// Stall: a two-entry output buffer holds results; when it and the read stage
// would overflow, in_ready_o drops, but only while a frame is held.
// Reset: nothing is held, fill starts at position 0 of bank 0, mode is cw.
// The mode register is written at any edge with cfg_we_i high; each result
// uses the mode in force when its read is issued.
module square_image_rotate_flip (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  sirf_pkg::in_beat_t        in_beat_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output sirf_pkg::out_beat_t       out_beat_o
);
  import sirf_pkg::*;

  mode_e             mode_q;
  logic              fill_bank_q, fill_bank_d;
  logic [SIDE_W-1:0] fill_row_q, fill_row_d, fill_col_q, fill_col_d;
  logic [SIDE_W-1:0] emit_row_q, emit_row_d, emit_col_q, emit_col_d;
  logic              held_q, held_d;
  logic              rd_vld_q, rd_vld_d;
  logic              rd_last_q, rd_last_d;

  logic              accept;
  logic              emit_last;
  logic              fill_last;
  logic              pop;
  logic              room;
  logic [1:0]        occ;
  wr_req_t           wr_req;
  rd_req_t           rd_req;
  logic [PIX_W-1:0]  rdata;
  out_beat_t         push_beat;
  ob_status_t        ob_status;

  // occupancy of output buffer plus the read in flight
  assign pop  = out_valid_o && out_ready_i;
  assign occ  = 2'(ob_status.head_valid) + 2'(ob_status.skid_valid) + 2'(rd_vld_q);
  assign room = (occ <= 2'd1) || ((occ == 2'd2) && pop);

  assign in_ready_o = !held_q || room;
  assign accept     = in_valid_i && in_ready_o;

  assign emit_last = (emit_row_q == SIDE_LAST) && (emit_col_q == SIDE_LAST);
  assign fill_last = (fill_row_q == SIDE_LAST) && (fill_col_q == SIDE_LAST);

  // Read and write always hit different banks; a frame's last write lands
  // before its first read is issued, so no forwarding is needed.
  always_comb begin
    rd_req.en    = accept && held_q;
    rd_req.addr  = map_addr(~fill_bank_q, emit_row_q, emit_col_q, mode_q);
    wr_req.en    = accept && (in_beat_i.kind == KIND_PIXEL);
    wr_req.addr  = raster_addr(fill_bank_q, fill_row_q, fill_col_q);
    wr_req.data  = in_beat_i.pixel;
  end

  always_comb begin
    fill_bank_d = fill_bank_q;
    fill_row_d  = fill_row_q;
    fill_col_d  = fill_col_q;
    emit_row_d  = emit_row_q;
    emit_col_d  = emit_col_q;
    held_d      = held_q;
    rd_vld_d    = rd_req.en;
    rd_last_d   = emit_last;
    if (rd_req.en) begin
      if (emit_col_q == SIDE_LAST) begin
        emit_col_d = '0;
        emit_row_d = emit_row_q + SIDE_W'(1);
      end else begin
        emit_col_d = emit_col_q + SIDE_W'(1);
      end
      if (emit_last) begin
        held_d = 1'b0;
      end
    end
    if (wr_req.en) begin
      if (fill_col_q == SIDE_LAST) begin
        fill_col_d = '0;
        fill_row_d = fill_row_q + SIDE_W'(1);
      end else begin
        fill_col_d = fill_col_q + SIDE_W'(1);
      end
      if (fill_last) begin
        fill_row_d  = '0;
        fill_col_d  = '0;
        fill_bank_d = ~fill_bank_q;
        held_d      = 1'b1;
        emit_row_d  = '0;
        emit_col_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CW;
      fill_bank_q <= 1'b0;
      fill_row_q  <= '0;
      fill_col_q  <= '0;
      emit_row_q  <= '0;
      emit_col_q  <= '0;
      held_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= mode_e'(cfg_wdata_i);
      end
      fill_bank_q <= fill_bank_d;
      fill_row_q  <= fill_row_d;
      fill_col_q  <= fill_col_d;
      emit_row_q  <= emit_row_d;
      emit_col_q  <= emit_col_d;
      held_q      <= held_d;
      rd_vld_q    <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req.en) begin
      rd_last_q <= rd_last_d;
    end
  end

  sirf_frame_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (wr_req),
    .rd_i    (rd_req),
    .rdata_o (rdata)
  );

  assign push_beat.out_pixel  = rdata;
  assign push_beat.frame_last = rd_last_q;

  sirf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rd_vld_q),
    .push_beat_i (push_beat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o),
    .status_o    (ob_status)
  );

  // read data must always find a free buffer slot
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> !(ob_status.skid_valid && !pop))
    else $error("output buffer overflow");

  a_skid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_status.skid_valid |-> ob_status.head_valid)
    else $error("skid entry without head entry");

  a_emit_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && held_q) |=> rd_vld_q)
    else $error("emitting beat issued no read");

  a_last_ends_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_req.en && emit_last && !(wr_req.en && fill_last)) |=> !held_q)
    else $error("hold not released after last pixel");

endmodule

// File: rtl/core/sirf_frame_mem.sv
// Two-bank frame store: one write port, one read port, registered read data.
// Depends on sirf_pkg.
module sirf_frame_mem (
  input  logic                   clk_i,
  input  sirf_pkg::wr_req_t      wr_i,
  input  sirf_pkg::rd_req_t      rd_i,
  output logic [sirf_pkg::PIX_W-1:0] rdata_o
);
  import sirf_pkg::*;

  logic [PIX_W-1:0] mem [STORE_DEPTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sirf_out_buf.sv
// Output register plus one skid entry between the memory read stage and
// the result channel. Depends on sirf_pkg.
module sirf_out_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sirf_pkg::out_beat_t    push_beat_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sirf_pkg::out_beat_t    out_beat_o,
  output sirf_pkg::ob_status_t   status_o
);
  import sirf_pkg::*;

  logic      head_valid_q, head_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_beat_t head_q, head_d;
  out_beat_t skid_q, skid_d;
  logic      pop;

  assign pop = head_valid_q && out_ready_i;

  always_comb begin
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    head_d       = head_q;
    skid_d       = skid_q;
    if (pop || !head_valid_q) begin
      if (skid_valid_q) begin
        head_valid_d = 1'b1;
        head_d       = skid_q;
        skid_valid_d = push_i;
        skid_d       = push_beat_i;
      end else begin
        head_valid_d = push_i;
        head_d       = push_beat_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o         = head_valid_q;
  assign out_beat_o          = head_q;
  assign status_o.head_valid = head_valid_q;
  assign status_o.skid_valid = skid_valid_q;

endmodule
